@@ rtl/vfd_pkg.sv @@
// Shared types, constants and sample arithmetic for the frame decoder.
package vfd_pkg;

	localparam int unsigned NUM_PREDICTORS_DEF = 8;
	localparam int unsigned NUM_LANES = 8;
	localparam int unsigned FRAME_SAMPLES = 16;

	localparam logic [2:0] MODE_WRITE_COEF = 3'd0;
	localparam logic [2:0] MODE_CLEAR_HIST = 3'd1;
	localparam logic [2:0] MODE_LOOP_HIST = 3'd2;
	localparam logic [2:0] MODE_GIVEN_HIST = 3'd3;
	localparam logic [2:0] MODE_DECODE_4 = 3'd4;
	localparam logic [2:0] MODE_DECODE_2 = 3'd5;

	localparam logic APB_REG_LOOP_NEWEST = 1'b0;
	localparam logic APB_REG_LOOP_OLDER = 1'b1;

	typedef logic signed [15:0] smp_t;
	typedef smp_t [NUM_LANES-1:0] smp_vec_t;

	typedef struct packed {
		logic clear;
		logic mac;
		logic [2:0] step;
	} lane_ctrl_t;

	function automatic smp_t decode_code(input logic [63:0] codes, input logic two_bit,
			input logic [3:0] shift, input logic [3:0] pos);
		logic [3:0] raw4;
		logic [1:0] raw2;
		logic [15:0] ext;
		begin
			raw4 = 4'(codes >> (7'd60 - {1'b0, pos, 2'b00}));
			raw2 = 2'(codes >> (7'd62 - {2'b00, pos, 1'b0}));
			if (two_bit) begin
				ext = {{14{raw2[1]}}, raw2};
			end else begin
				ext = {{12{raw4[3]}}, raw4};
			end
			return smp_t'(ext << shift);
		end
	endfunction

	function automatic smp_t sat_acc(input logic signed [31:0] acc);
		logic signed [20:0] v;
		begin
			v = acc[31:11];
			if (v > 21'sd32767) begin
				return 16'sh7FFF;
			end else if (v < -21'sd32768) begin
				return 16'sh8000;
			end
			return smp_t'(v[15:0]);
		end
	endfunction

endpackage

@@ rtl/vadpcm_frame_decoder.sv @@
// Top level of the order-2 adaptive predictive PCM frame decoder.
// Codebook writes and history items are taken in the idle state, which stays ready for the
// next item. A frame is decoded as two groups of eight samples by eight lanes; each group
// unpacks its codes, issues eight two-port codebook reads and drains the multiply-accumulate
// pipeline, and the second group waits for the history left by the first. The sixteen samples
// then leave at one transfer per cycle while result_ready is high, and the next item is taken
// after the last sample's transfer.
module vadpcm_frame_decoder import vfd_pkg::*; #(
	parameter int unsigned NUM_PREDICTORS = NUM_PREDICTORS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  mode,
	input  logic [6:0]  coef_index,
	input  logic signed [15:0] coef_value,
	input  logic signed [15:0] given_newest,
	input  logic signed [15:0] given_older,
	input  logic [7:0]  frame_header,
	input  logic [63:0] frame_codes,
	output logic        result_valid,
	input  logic        result_ready,
	output logic signed [15:0] sample,
	output logic [3:0]  sample_pos,
	output logic        last
);

	localparam int unsigned CB_DEPTH = NUM_PREDICTORS * 16;
	localparam int unsigned CB_AW = $clog2(CB_DEPTH);

	typedef enum logic [2:0] {S_IDLE, S_LOAD, S_RUN, S_DRAIN, S_OUT} state_t;

	function automatic logic [3:0] pred_mod(input logic [3:0] nib);
		logic [4:0] r;
		begin
			r = {1'b0, nib};
			for (int i = 0; i < 16; i++) begin
				if (r >= 5'(NUM_PREDICTORS)) begin
					r = r - 5'(NUM_PREDICTORS);
				end
			end
			return r[3:0];
		end
	endfunction

	state_t state_q;
	smp_t loop_newest_q;
	smp_t loop_older_q;
	smp_t hist_newest_q;
	smp_t hist_older_q;
	logic [63:0] codes_q;
	logic [3:0] shift_q;
	logic two_bit_q;
	logic [CB_AW-1:0] base_q;
	logic grp_q;
	logic [2:0] step_q;
	logic [1:0] drain_q;
	logic [3:0] pos_q;
	logic mac_s1;
	logic [2:0] step_s1;
	smp_vec_t ins_q;
	smp_t buf_q [FRAME_SAMPLES];
	smp_vec_t res;
	smp_t coef_a;
	smp_t coef_b;
	lane_ctrl_t ctrl;
	logic item_xfer;
	logic cb_wr;
	logic issue;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == APB_REG_LOOP_OLDER) ? {16'b0, loop_older_q}
		: {16'b0, loop_newest_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_newest_q <= '0;
			loop_older_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == APB_REG_LOOP_NEWEST) begin
				loop_newest_q <= smp_t'(pwdata[15:0]);
			end else begin
				loop_older_q <= smp_t'(pwdata[15:0]);
			end
		end
	end

	assign item_ready = (state_q == S_IDLE);
	assign item_xfer = item_valid && item_ready;
	assign cb_wr = item_xfer && (mode == MODE_WRITE_COEF) && (32'(coef_index) < CB_DEPTH);
	assign issue = (state_q == S_RUN);

	assign ctrl.clear = issue && (step_q == 3'd0);
	assign ctrl.mac = mac_s1;
	assign ctrl.step = step_s1;

	vfd_codebook #(
		.DEPTH(CB_DEPTH)
	) u_codebook (
		.clk      (clk),
		.wr_en    (cb_wr),
		.wr_addr  (CB_AW'(coef_index)),
		.wr_data  (coef_value),
		.rd_en    (issue),
		.rd_addr_a(base_q + CB_AW'(step_q)),
		.rd_addr_b(base_q + CB_AW'(step_q) + CB_AW'(8)),
		.rd_data_a(coef_a),
		.rd_data_b(coef_b)
	);

	for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
		vfd_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.lane_idx(3'(j)),
			.ctrl    (ctrl),
			.coef_a  (coef_a),
			.coef_b  (coef_b),
			.p1      (hist_newest_q),
			.p2      (hist_older_q),
			.ins     (ins_q),
			.res     (res[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hist_newest_q <= '0;
			hist_older_q <= '0;
			grp_q <= 1'b0;
			step_q <= '0;
			drain_q <= '0;
			pos_q <= '0;
			mac_s1 <= 1'b0;
			step_s1 <= '0;
		end else begin
			mac_s1 <= issue;
			step_s1 <= step_q;
			case (state_q)
				S_IDLE: begin
					if (item_xfer) begin
						case (mode)
							MODE_CLEAR_HIST: begin
								hist_newest_q <= '0;
								hist_older_q <= '0;
							end
							MODE_LOOP_HIST: begin
								hist_newest_q <= loop_newest_q;
								hist_older_q <= loop_older_q;
							end
							MODE_GIVEN_HIST: begin
								hist_newest_q <= given_newest;
								hist_older_q <= given_older;
							end
							MODE_DECODE_4, MODE_DECODE_2: begin
								grp_q <= 1'b0;
								state_q <= S_LOAD;
							end
							default: begin
							end
						endcase
					end
				end
				S_LOAD: begin
					step_q <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						drain_q <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd2) begin
						hist_newest_q <= res[7];
						hist_older_q <= res[6];
						if (grp_q) begin
							pos_q <= '0;
							state_q <= S_OUT;
						end else begin
							grp_q <= 1'b1;
							state_q <= S_LOAD;
						end
					end
				end
				S_OUT: begin
					if (result_ready) begin
						pos_q <= pos_q + 4'd1;
						if (pos_q == 4'd15) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			codes_q <= frame_codes;
			shift_q <= frame_header[7:4];
			two_bit_q <= (mode == MODE_DECODE_2);
			base_q <= CB_AW'({pred_mod(frame_header[3:0]), 4'b0000});
		end
		if (state_q == S_LOAD) begin
			for (int j = 0; j < NUM_LANES; j++) begin
				ins_q[j] <= decode_code(codes_q, two_bit_q, shift_q, {grp_q, 3'(j)});
			end
		end
		if ((state_q == S_DRAIN) && (drain_q == 2'd2)) begin
			for (int j = 0; j < NUM_LANES; j++) begin
				buf_q[{grp_q, 3'(j)}] <= res[j];
			end
		end
	end

	assign result_valid = (state_q == S_OUT);
	assign sample = buf_q[pos_q];
	assign sample_pos = pos_q;
	assign last = (pos_q == 4'd15);

endmodule

@@ rtl/vfd_codebook.sv @@
// Predictor coefficient memory with one write port and two registered read ports.
module vfd_codebook import vfd_pkg::*; #(
	parameter int unsigned DEPTH = NUM_PREDICTORS_DEF * 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  smp_t          wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	output smp_t          rd_data_a,
	output smp_t          rd_data_b
);

	smp_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

@@ rtl/vfd_lane.sv @@
// One prediction lane: accumulates the filter terms of one sample of a group.
module vfd_lane import vfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [2:0] lane_idx,
	input  lane_ctrl_t ctrl,
	input  smp_t       coef_a,
	input  smp_t       coef_b,
	input  smp_t       p1,
	input  smp_t       p2,
	input  smp_vec_t   ins,
	output smp_t       res
);

	smp_t op_a;
	smp_t op_b;
	logic signed [31:0] prod_a;
	logic signed [31:0] prod_b;
	logic signed [31:0] prod_a_s2;
	logic signed [31:0] prod_b_s2;
	logic prod_vld_s2;
	logic signed [31:0] acc_q;

	always_comb begin
		op_a = '0;
		op_b = '0;
		if (ctrl.step == lane_idx) begin
			op_a = p2;
			op_b = p1;
		end else if (ctrl.step < lane_idx) begin
			op_b = ins[3'(lane_idx - ctrl.step - 3'd1)];
		end
	end

	assign prod_a = coef_a * op_a;
	assign prod_b = coef_b * op_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s2 <= 1'b0;
		end else begin
			prod_vld_s2 <= ctrl.mac;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mac) begin
			prod_a_s2 <= prod_a;
			prod_b_s2 <= prod_b;
		end
		if (ctrl.clear) begin
			acc_q <= 32'(ins[lane_idx]) <<< 11;
		end else if (prod_vld_s2) begin
			acc_q <= acc_q + prod_a_s2 + prod_b_s2;
		end
	end

	assign res = sat_acc(acc_q);

endmodule
